### rtl/serm_pkg.sv
`timescale 1ns / 1ps

package serm_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // configuration register indexes
    localparam logic CFG_TONE = 1'b0;
    localparam logic CFG_DRUM = 1'b1;

    localparam logic [6:0] FACTOR_RESET = 7'd32;
    localparam logic [7:0] GAIN_BASE    = 8'd16;
    localparam logic [7:0] GAIN_MAX     = 8'd127;

    localparam logic signed [31:0] LEVEL_THRESH = 32'sh100;
    localparam logic signed [31:0] CLAMP_MIN    = -32'sh8000;
    localparam logic signed [31:0] CLAMP_MAX    = 32'sh0000_ffff >>> 1;

    // one stereo word of either store, left in the low half
    typedef struct packed {
        logic [31:0] right;
        logic [31:0] left;
    } t_stereo;

    function automatic logic [15:0] clamp16(input logic [31:0] v);
        logic signed [31:0] s;
        s = $signed(v);
        if (s < CLAMP_MIN) begin
            return CLAMP_MIN[15:0];
        end else if (s > CLAMP_MAX) begin
            return CLAMP_MAX[15:0];
        end
        return v[15:0];
    endfunction

endpackage

### rtl/serm_echo_mem.sv
`timescale 1ns / 1ps

module serm_echo_mem
    import serm_pkg::*;
#(
    parameter int AW = 14
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  t_stereo         i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr_a,
    input  logic [AW-1:0]   i_raddr_b,
    output t_stereo         o_rdata_a,
    output t_stereo         o_rdata_b
);

    t_stereo r_mem [2**AW];
    t_stereo r_rdata_a;
    t_stereo r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/serm_mix_mem.sv
`timescale 1ns / 1ps

module serm_mix_mem
    import serm_pkg::*;
#(
    parameter int AW = 9
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  t_stereo         i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output t_stereo         o_rdata
);

    t_stereo r_mem [2**AW];
    t_stereo r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/stereo_echo_reverb_mixer_core.sv
`timescale 1ns / 1ps
// A channel sample runs through the states TAP, MUL, ADD, MIX and LVL and loads its
// result into the output register in LVL; a readout loads its result in RD. Either
// waits there until the output register is free. A frame start gives no result.
// A new transaction is taken only in IDLE, once the single read-modify-write sequence
// through the echo and mix memories is done. Reset: synchronous, active low; afterwards
// a clearing pass over all 2**(BW+CW+IW) addresses zeroes both memories; tready stays low.

module stereo_echo_reverb_mixer_core
    import serm_pkg::*;
#(
    parameter int CHANNELS  = 16,
    parameter int FRAME_LEN = 512,
    parameter int BANKS     = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wen,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] channel, [12:4] sample_index, [44:13] dry_left, [76:45] dry_right,
    // [83:77] reverb_send, [87:84] zero
    input  logic [87:0] i_s_axis_tdata,
    // [1:0] operation, [2] drum_map
    input  logic [2:0]  i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] mixed_word, [32] channel_active, [39:33] zero
    output logic [39:0] o_m_axis_tdata
);

    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW  = $clog2(FRAME_LEN);
    localparam int BW  = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int EAW = BW + CW + IW;

    // sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_TAP  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_MIX  = 3'd5;
    localparam logic [2:0] S_LVL  = 3'd6;
    localparam logic [2:0] S_RD   = 3'd7;

    // unpack the input transaction
    logic [1:0]  w_op;
    logic        w_drum;
    logic [3:0]  w_ch;
    logic [8:0]  w_idx;
    logic [31:0] w_dry_l;
    logic [31:0] w_dry_r;
    logic [6:0]  w_send;

    assign w_op    = i_s_axis_tuser[1:0];
    assign w_drum  = i_s_axis_tuser[2];
    assign w_ch    = i_s_axis_tdata[3:0];
    assign w_idx   = i_s_axis_tdata[12:4];
    assign w_dry_l = i_s_axis_tdata[44:13];
    assign w_dry_r = i_s_axis_tdata[76:45];
    assign w_send  = i_s_axis_tdata[83:77];

    // control registers
    logic [2:0]     r_state, n_state;
    logic [EAW-1:0] r_clr_addr;
    logic [BW-1:0]  r_bank;
    logic           r_flag, n_flag;
    logic [6:0]     r_factor_tone;
    logic [6:0]     r_factor_drum;
    logic           r_out_valid;

    // payload registers
    logic [CW-1:0]  r_ch;
    logic [IW-1:0]  r_idx;
    logic [31:0]    r_dry_l;
    logic [31:0]    r_dry_r;
    logic [14:0]    r_gain;
    logic [31:0]    r_sum_l;
    logic [31:0]    r_sum_r;
    logic [31:0]    r_scl_l;
    logic [31:0]    r_scl_r;
    t_stereo        r_new;
    t_stereo        r_mix_new;
    logic [32:0]    r_out_data;

    // memory ports
    logic           w_echo_we;
    logic [EAW-1:0] w_echo_waddr;
    t_stereo        w_echo_wdata;
    logic           w_echo_re;
    logic [EAW-1:0] w_echo_raddr_a;
    logic [EAW-1:0] w_echo_raddr_b;
    t_stereo        w_echo_rdata_a;
    t_stereo        w_echo_rdata_b;
    logic           w_mix_we;
    logic [IW-1:0]  w_mix_waddr;
    t_stereo        w_mix_wdata;
    logic           w_mix_re;
    t_stereo        w_mix_rdata;

    // handshake and decode
    logic           w_accept;
    logic           w_ch_ok;
    logic           w_idx_ok;
    logic           w_start_tap;
    logic           w_start_rd;
    logic           w_out_free;
    logic           w_out_load;
    logic [32:0]    n_out_data;
    logic [IW-1:0]  w_idx_cur;
    logic [IW-1:0]  w_idx_next;
    logic [7:0]     w_send_sum;
    logic [6:0]     w_gain_sat;
    logic [6:0]     w_factor;
    logic [13:0]    w_gain_prod;
    logic signed [47:0] w_prod_l;
    logic signed [47:0] w_prod_r;
    logic [31:0]    w_level;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ch_ok         = int'(w_ch) < CHANNELS;
    assign w_idx_ok        = int'(w_idx) < FRAME_LEN;
    assign w_start_tap     = w_accept && (w_op == OP_SAMPLE) && w_ch_ok && w_idx_ok;
    assign w_start_rd      = w_accept && (w_op == OP_READ) && w_idx_ok;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // second tap: the next entry, or the same one at the end of the frame
    assign w_idx_cur  = IW'(w_idx);
    assign w_idx_next = (int'(w_idx) + 1 < FRAME_LEN) ? IW'(int'(w_idx) + 1) : w_idx_cur;

    // gain = min(16 + send, 127) * factor * 2
    assign w_send_sum  = {1'b0, w_send} + GAIN_BASE;
    assign w_gain_sat  = (w_send_sum > GAIN_MAX) ? GAIN_MAX[6:0] : w_send_sum[6:0];
    assign w_factor    = w_drum ? r_factor_drum : r_factor_tone;
    assign w_gain_prod = 14'(w_gain_sat) * 14'(w_factor);

    // Q16 scaling; left taps feed the right channel and vice versa
    assign w_prod_r = 48'($signed(r_sum_l)) * 48'($signed({1'b0, r_gain}));
    assign w_prod_l = 48'($signed(r_sum_r)) * 48'($signed({1'b0, r_gain}));

    assign w_level = r_mix_new.left + r_mix_new.right;

    // memory read side: issue all reads with the accepted transaction
    assign w_echo_re      = w_start_tap;
    assign w_echo_raddr_a = {r_bank, CW'(w_ch), w_idx_cur};
    assign w_echo_raddr_b = {r_bank, CW'(w_ch), w_idx_next};
    assign w_mix_re       = w_start_tap || w_start_rd;

    // memory write side: the clearing pass, the wet write-back and the mix update
    always_comb begin
        w_echo_we    = 1'b0;
        w_echo_waddr = r_clr_addr;
        w_echo_wdata = '0;
        w_mix_we     = 1'b0;
        w_mix_waddr  = r_idx;
        w_mix_wdata  = '0;
        priority case (1'b1)
            (r_state == S_CLR): begin
                w_echo_we   = 1'b1;
                w_mix_we    = 1'b1;
                w_mix_waddr = r_clr_addr[IW-1:0];
            end
            (r_state == S_MIX): begin
                // write back the wet pair and the updated mix together
                w_echo_we    = 1'b1;
                w_echo_waddr = {r_bank, r_ch, r_idx};
                w_echo_wdata = r_new;
                w_mix_we     = 1'b1;
                w_mix_wdata  = r_mix_new;
            end
            (r_state == S_RD): begin
                // clear the entry as the readout leaves
                w_mix_we = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_flag     = r_flag;
        w_out_load = 1'b0;
        n_out_data = r_out_data;
        unique case (r_state)
            S_CLR: begin
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_start_tap) begin
                    n_state = S_TAP;
                end else if (w_start_rd) begin
                    n_state = S_RD;
                end
            end
            S_TAP: n_state = S_MUL;
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_MIX;
            S_MIX: n_state = S_LVL;
            S_LVL: begin
                if (w_out_free) begin
                    n_flag = ((r_idx == '0) ? 1'b0 : r_flag) ||
                             ($signed(w_level) > LEVEL_THRESH);
                    w_out_load = 1'b1;
                    n_out_data = {n_flag, 32'd0};
                    n_state    = S_IDLE;
                end
            end
            S_RD: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_out_data = {1'b0, clamp16(w_mix_rdata.right),
                                  clamp16(w_mix_rdata.left)};
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_clr_addr    <= '0;
            r_bank        <= '0;
            r_flag        <= 1'b0;
            r_factor_tone <= FACTOR_RESET;
            r_factor_drum <= FACTOR_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flag  <= n_flag;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // advance the bank on a frame start
            if (w_accept && (w_op == OP_FRAME)) begin
                r_bank <= (int'(r_bank) == BANKS - 1) ? '0 : r_bank + 1'b1;
            end
            if (i_cfg_wen) begin
                unique case (i_cfg_addr)
                    CFG_TONE: r_factor_tone <= i_cfg_wdata;
                    CFG_DRUM: r_factor_drum <= i_cfg_wdata;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch    <= CW'(w_ch);
            r_idx   <= w_idx_cur;
            r_dry_l <= w_dry_l;
            r_dry_r <= w_dry_r;
            r_gain  <= {w_gain_prod, 1'b0};
        end
        if (r_state == S_TAP) begin
            r_sum_l <= w_echo_rdata_a.left + w_echo_rdata_b.left;
            r_sum_r <= w_echo_rdata_a.right + w_echo_rdata_b.right;
        end
        if (r_state == S_MUL) begin
            r_scl_l <= w_prod_l[47:16];
            r_scl_r <= w_prod_r[47:16];
        end
        if (r_state == S_ADD) begin
            r_new.left  <= r_scl_l + r_dry_l;
            r_new.right <= r_scl_r + r_dry_r;
        end
        if (r_state == S_ADD) begin
            r_mix_new.left  <= w_mix_rdata.left + r_scl_l + r_dry_l;
            r_mix_new.right <= w_mix_rdata.right + r_scl_r + r_dry_r;
        end
        if (w_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_data};

    serm_echo_mem #(
        .AW (EAW)
    ) u_echo_mem (
        .i_clk     (i_clk),
        .i_we      (w_echo_we),
        .i_waddr   (w_echo_waddr),
        .i_wdata   (w_echo_wdata),
        .i_re      (w_echo_re),
        .i_raddr_a (w_echo_raddr_a),
        .i_raddr_b (w_echo_raddr_b),
        .o_rdata_a (w_echo_rdata_a),
        .o_rdata_b (w_echo_rdata_b)
    );

    serm_mix_mem #(
        .AW (IW)
    ) u_mix_mem (
        .i_clk   (i_clk),
        .i_we    (w_mix_we),
        .i_waddr (w_mix_waddr),
        .i_wdata (w_mix_wdata),
        .i_re    (w_mix_re),
        .i_raddr (w_idx_cur),
        .o_rdata (w_mix_rdata)
    );

    // no transaction is taken while the memories are being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !w_accept)
        else $error("transaction accepted during clearing pass");

    // the bank pointer stays inside the configured bank count
    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_bank) < BANKS)
        else $error("bank select out of range");

    // a valid sample transaction starts the tap read sequence
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start_tap |=> (r_state == S_TAP))
        else $error("sample transaction did not start tap sequence");

    // echo writes happen only in the clearing pass or the write-back stage
    a_echo_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_echo_we |-> ((r_state == S_CLR) || (r_state == S_MIX)))
        else $error("echo write outside clearing pass or write-back");

    // a readout result never carries the active flag
    a_read_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) && w_out_load) |=> !r_out_data[32])
        else $error("readout result carries active flag");

endmodule

### tb/serm_mix_checker.sv
`timescale 1ns / 1ps

module serm_mix_checker
    import serm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    // [3:0] channel, [12:4] sample_index, [44:13] dry_left, [76:45] dry_right,
    // [83:77] reverb_send, [87:84] zero
    input  logic [87:0] i_s_axis_tdata,
    // [1:0] operation, [2] drum_map
    input  logic [2:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] mixed_word, [32] channel_active, [39:33] zero
    input  logic [39:0] i_m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int N_CHAN  = 16;
    localparam int N_INDEX = 512;
    localparam int N_BANK  = 2;

    typedef struct {
        logic [31:0] mixed_word;
        logic        active;
    } t_mix_result;

    t_stereo     echo_mem [N_BANK][N_CHAN][N_INDEX];
    t_stereo     mix_acc  [N_INDEX];
    int          bank_sel;
    logic        active_flag;
    logic [6:0]  factor_tone;
    logic [6:0]  factor_drum;
    t_mix_result expected_mix_q [$];
    int          fail_count;

    // bits 47..16 of the signed sum times the unsigned gain
    function automatic logic [31:0] q16_scale(input logic [31:0] sum, input logic [15:0] gain);
        logic signed [63:0] prod;
        prod = $signed({{32{sum[31]}}, sum}) * $signed({48'd0, gain});
        return prod[47:16];
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        if ($signed(v) < -32'sd32768) begin
            return 16'h8000;
        end
        if ($signed(v) > 32'sd32767) begin
            return 16'h7fff;
        end
        return v[15:0];
    endfunction

    task automatic clear_mix_state();
        for (int b = 0; b < N_BANK; b++) begin
            for (int c = 0; c < N_CHAN; c++) begin
                for (int i = 0; i < N_INDEX; i++) begin
                    echo_mem[b][c][i] = '0;
                end
            end
        end
        for (int i = 0; i < N_INDEX; i++) begin
            mix_acc[i] = '0;
        end
        bank_sel    = 0;
        active_flag = 1'b0;
        factor_tone = FACTOR_RESET;
        factor_drum = FACTOR_RESET;
        expected_mix_q.delete();
    endtask

    // advance the predicted state by one accepted transaction, queue any result
    task automatic predict_reverb_mix(input logic [87:0] data, input logic [2:0] user);
        logic [1:0]  op;
        logic        drum;
        logic [3:0]  ch;
        logic [8:0]  idx;
        logic [8:0]  nxt;
        logic [31:0] dry_l;
        logic [31:0] dry_r;
        logic [6:0]  send;
        logic [7:0]  base_gain;
        logic [6:0]  factor;
        logic [15:0] gain;
        logic [31:0] sum_l;
        logic [31:0] sum_r;
        logic [31:0] new_l;
        logic [31:0] new_r;
        logic [31:0] level;
        t_mix_result res;
        op    = user[1:0];
        drum  = user[2];
        ch    = data[3:0];
        idx   = data[12:4];
        dry_l = data[44:13];
        dry_r = data[76:45];
        send  = data[83:77];
        case (op)
            OP_FRAME: begin
                bank_sel = (bank_sel + 1) % N_BANK;
            end
            OP_SAMPLE: begin
                nxt       = (int'(idx) == N_INDEX - 1) ? idx : idx + 9'd1;
                factor    = drum ? factor_drum : factor_tone;
                base_gain = GAIN_BASE + {1'b0, send};
                if (base_gain > GAIN_MAX) begin
                    base_gain = GAIN_MAX;
                end
                gain  = 16'(base_gain) * 16'(factor) * 16'd2;
                sum_l = echo_mem[bank_sel][ch][idx].left + echo_mem[bank_sel][ch][nxt].left;
                sum_r = echo_mem[bank_sel][ch][idx].right + echo_mem[bank_sel][ch][nxt].right;
                // cross-feed: the left taps feed the right wet sample and vice versa
                new_r = q16_scale(sum_l, gain) + dry_r;
                new_l = q16_scale(sum_r, gain) + dry_l;
                echo_mem[bank_sel][ch][idx].left  = new_l;
                echo_mem[bank_sel][ch][idx].right = new_r;
                mix_acc[idx].left  = mix_acc[idx].left + new_l;
                mix_acc[idx].right = mix_acc[idx].right + new_r;
                if (idx == 9'd0) begin
                    active_flag = 1'b0;
                end
                level = mix_acc[idx].left + mix_acc[idx].right;
                if ($signed(level) > LEVEL_THRESH) begin
                    active_flag = 1'b1;
                end
                res.mixed_word = '0;
                res.active     = active_flag;
                expected_mix_q.push_back(res);
            end
            OP_READ: begin
                res.mixed_word = {sat16(mix_acc[idx].right), sat16(mix_acc[idx].left)};
                res.active     = 1'b0;
                mix_acc[idx]   = '0;
                expected_mix_q.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_mix_result want;
        if (!i_rst_n) begin
            clear_mix_state();
            fail_count = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_mix_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, i_m_axis_tdata);
                end else begin
                    want = expected_mix_q.pop_front();
                    if (i_m_axis_tdata[31:0] !== want.mixed_word) begin
                        fail_count++;
                        $display("%0t: mixed_word expected %h actual %h",
                                 $time, want.mixed_word, i_m_axis_tdata[31:0]);
                    end
                    if (i_m_axis_tdata[32] !== want.active) begin
                        fail_count++;
                        $display("%0t: channel_active expected %b actual %b",
                                 $time, want.active, i_m_axis_tdata[32]);
                    end
                    if (i_m_axis_tdata[39:33] !== 7'd0) begin
                        fail_count++;
                        $display("%0t: padding expected %h actual %h",
                                 $time, 7'd0, i_m_axis_tdata[39:33]);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_reverb_mix(i_s_axis_tdata, i_s_axis_tuser);
            end
            if (i_cfg_wen) begin
                if (i_cfg_addr == CFG_TONE) begin
                    factor_tone = i_cfg_wdata;
                end else begin
                    factor_drum = i_cfg_wdata;
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_mix_q.size();
    end

endmodule

### tb/tb_stereo_echo_reverb_mixer_core.sv
`timescale 1ns / 1ps

module tb_stereo_echo_reverb_mixer_core;
    import serm_pkg::*;

    // operation code the block must ignore; the package names only the live ones
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [8:0] INDEX_LAST = 9'd511;
    localparam int         PHASE_ITEMS = 220;
    localparam int         N_PHASES    = 5;
    // cycles to let a result-free transaction finish before touching the registers
    localparam int         SETTLE_CYCLES = 12;
    localparam int         HOLD_AT_RESULT = 150;
    localparam int         HOLD_CYCLES    = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [3:0] channel, [12:4] sample_index, [44:13] dry_left, [76:45] dry_right,
    // [83:77] reverb_send, [87:84] zero
    logic [87:0] i_s_axis_tdata = '0;
    // [1:0] operation, [2] drum_map
    logic [2:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [31:0] mixed_word, [32] channel_active, [39:33] zero
    logic [39:0] o_m_axis_tdata;

    int fail_count;
    int pending;
    int offered;
    int counted;

    stereo_echo_reverb_mixer_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    serm_mix_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offer one transaction: idle for a drawn gap, then present the item at the
    // falling edge and hold it until the rising edge that accepts it. Every fourth
    // stretch of 40 items runs back to back with no gaps at all.
    task automatic offer_item(input logic [1:0] op, input logic [3:0] ch,
                              input logic [8:0] idx, input logic [31:0] dry_l,
                              input logic [31:0] dry_r, input logic [6:0] send,
                              input logic drum);
        int gap;
        gap = ((offered / 40) % 4 == 3) ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tdata  <= {4'd0, send, dry_r, dry_l, idx, ch};
        i_s_axis_tuser  <= {drum, op};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        offered++;
        if (op != OP_UNUSED) begin
            counted++;
        end
    endtask

    // Drop valid, wait until every predicted result is back, then allow the
    // block a few more cycles in case a frame start is still in flight.
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_factor(input logic addr, input logic [6:0] value);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // Mostly small values so the level threshold and the clamp both get exercised;
    // now and then the full 32-bit range and its extremes.
    function automatic logic [31:0] draw_dry();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(0, 1200) - 32'd600;
        endcase
    endfunction

    // Edges of every field, the last index with its single tap, the send clamp,
    // the level threshold on either side, echo from two frames back, both clamp
    // directions on readout, and an unused operation.
    task automatic run_directed();
        offer_item(OP_SAMPLE, 4'd0, 9'd0, 32'h7fff_ffff, 32'h8000_0000, 7'd0, 1'b0);
        offer_item(OP_SAMPLE, 4'd15, INDEX_LAST, 32'h8000_0000, 32'h7fff_ffff, 7'd127, 1'b1);
        offer_item(OP_READ, 4'd0, 9'd0, '0, '0, '0, 1'b0);
        offer_item(OP_READ, 4'd15, INDEX_LAST, '1, '1, '1, 1'b1);
        offer_item(OP_UNUSED, 4'hf, 9'h1ff, '1, '1, '1, 1'b1);
        offer_item(OP_FRAME, 4'd0, 9'd0, '0, '0, '0, 1'b0);
        offer_item(OP_FRAME, 4'd0, 9'd0, '0, '0, '0, 1'b0);
        // back on the first bank: these pick up the wet samples written above
        offer_item(OP_SAMPLE, 4'd0, 9'd0, 32'd100, 32'd200, 7'd127, 1'b0);
        offer_item(OP_SAMPLE, 4'd15, INDEX_LAST, 32'd50, -32'd50, 7'd127, 1'b1);
        offer_item(OP_SAMPLE, 4'd0, 9'd1, 32'd300, 32'd0, 7'd64, 1'b0);
        offer_item(OP_SAMPLE, 4'd0, 9'd0, 32'd0, 32'd0, 7'd1, 1'b1);
        offer_item(OP_SAMPLE, 4'd1, 9'd2, 32'd128, 32'd128, 7'd10, 1'b0);
        offer_item(OP_SAMPLE, 4'd1, 9'd3, 32'd129, 32'd128, 7'd10, 1'b0);
        offer_item(OP_SAMPLE, 4'd7, 9'd255, 32'hffff_ffff, 32'd1, 7'd112, 1'b1);
        offer_item(OP_READ, 4'd0, 9'd0, '0, '0, '0, 1'b0);
        offer_item(OP_READ, 4'd0, 9'd1, '0, '0, '0, 1'b0);
        offer_item(OP_READ, 4'd0, 9'd2, '0, '0, '0, 1'b0);
        offer_item(OP_READ, 4'd0, 9'd3, '0, '0, '0, 1'b0);
        offer_item(OP_READ, 4'd0, 9'd255, '0, '0, '0, 1'b0);
        offer_item(OP_READ, 4'd0, INDEX_LAST, '0, '0, '0, 1'b0);
        offer_item(OP_READ, 4'd0, INDEX_LAST, '0, '0, '0, 1'b0);
        offer_item(OP_FRAME, 4'hf, 9'h1ff, '1, '1, '1, 1'b1);
    endtask

    // One frame of random traffic: a frame start, then samples clustered on a
    // handful of channels and a narrow index window so the same entries come
    // round again two frames later, sprinkled with readouts and the odd unused
    // operation; finish with a few readouts of the window.
    task automatic random_frame();
        logic [8:0] base;
        logic [8:0] idx;
        logic [3:0] ch;
        int         n;
        case ($urandom_range(0, 3))
            0: base = 9'd0;
            1: base = INDEX_LAST - 9'd5;
            default: base = 9'($urandom_range(0, 8));
        endcase
        offer_item(OP_FRAME, 4'($urandom), 9'($urandom), $urandom, $urandom,
                   7'($urandom), 1'($urandom));
        n = $urandom_range(4, 14);
        for (int k = 0; k < n; k++) begin
            ch  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            idx = ($urandom_range(0, 15) == 0) ? 9'($urandom)
                                                : base + 9'($urandom_range(0, 5));
            case ($urandom_range(0, 19))
                0: offer_item(OP_UNUSED, ch, idx, $urandom, $urandom, 7'($urandom),
                              1'($urandom));
                1, 2, 3: offer_item(OP_READ, ch, idx, draw_dry(), draw_dry(),
                                    7'($urandom), 1'($urandom));
                default: offer_item(OP_SAMPLE, ch, idx, draw_dry(), draw_dry(),
                                    7'($urandom_range(0, 127)), 1'($urandom));
            endcase
        end
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            offer_item(OP_READ, 4'($urandom), base + 9'($urandom_range(0, 5)), '0, '0,
                       '0, 1'b0);
        end
    endtask

    // Result side: stall for a drawn number of cycles before each transaction,
    // with calm stretches, and once hold off long enough to back up the input.
    initial begin
        int taken;
        int stall;
        taken = 0;
        forever begin
            if (taken == HOLD_AT_RESULT) begin
                stall = HOLD_CYCLES;
            end else if ((taken / 30) % 4 == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 5);
            end
            for (int k = 0; k < stall; k++) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            taken++;
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [6:0] tone_set [N_PHASES];
        logic [6:0] drum_set [N_PHASES];
        int         phase_end;
        offered = 0;
        counted = 0;
        tone_set = '{7'd127, 7'd0, 7'd127, 7'd0, 7'd1};
        drum_set = '{7'd127, 7'd127, 7'd0, 7'd0, 7'd126};
        // one phase with fresh random factors
        tone_set[3] = 7'($urandom);
        drum_set[3] = 7'($urandom);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        settle();
        for (int p = 0; p < N_PHASES; p++) begin
            write_factor(CFG_TONE, tone_set[p]);
            write_factor(CFG_DRUM, drum_set[p]);
            phase_end = counted + PHASE_ITEMS;
            while (counted < phase_end) random_frame();
            settle();
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: the clearing pass plus the slowest legal run fit well inside this.
    initial begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/serm_pkg.sv
rtl/serm_echo_mem.sv
rtl/serm_mix_mem.sv
rtl/stereo_echo_reverb_mixer_core.sv
tb/serm_mix_checker.sv
tb/tb_stereo_echo_reverb_mixer_core.sv
